/* rtl/core/vap_pkg.sv */
// Package with the word types, format codes and lane control types of the vertex attribute packer.
package vap_pkg;

    localparam int unsigned NumLanes = 4;

    localparam logic [3:0] MODE_F1   = 4'd0;
    localparam logic [3:0] MODE_F2   = 4'd1;
    localparam logic [3:0] MODE_F3   = 4'd2;
    localparam logic [3:0] MODE_F4   = 4'd3;
    localparam logic [3:0] MODE_S2   = 4'd4;
    localparam logic [3:0] MODE_S2N  = 4'd5;
    localparam logic [3:0] MODE_B4   = 4'd6;
    localparam logic [3:0] MODE_B4N  = 4'd7;
    localparam logic [3:0] MODE_UB4  = 4'd8;
    localparam logic [3:0] MODE_UB4N = 4'd9;
    localparam logic [3:0] MODE_S4   = 4'd10;
    localparam logic [3:0] MODE_S4N  = 4'd11;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] comp_x;
        logic [31:0] comp_y;
        logic [31:0] comp_z;
        logic [31:0] comp_w;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
        logic [4:0]  bytes_written;
        logic        unsupported;
    } t_out_word;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_PASS = 2'd1,
        KIND_INT  = 2'd2,
        KIND_NORM = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SCALE_127   = 2'd0,
        SCALE_255   = 2'd1,
        SCALE_32767 = 2'd2
    } t_scale;

    typedef struct packed {
        t_kind  kind;
        logic   is_signed;
        logic   byte_wide;
        t_scale scale;
    } t_lane_ctrl;

endpackage

/* rtl/core/vap_lane.sv */
// One conversion lane: float component to passthrough, clamped integer, normalized integer or zero.
module vap_lane (
    input  logic                i_clk,
    input  logic [31:0]         i_comp,
    input  vap_pkg::t_lane_ctrl i_ctrl,
    output logic [31:0]         o_res
);
    import vap_pkg::*;

    logic [31:0] r_comp;
    t_lane_ctrl  r_ctrl;
    logic        r_sign;
    logic [15:0] r_int_mag;
    logic        r_int_sat;
    logic [38:0] r_prod;
    logic        r_norm_zero;
    logic        r_norm_sat;
    logic [5:0]  r_norm_sh;

    logic        n_sign;
    logic [15:0] n_int_mag;
    logic        n_int_sat;
    logic [38:0] n_prod;
    logic        n_norm_zero;
    logic        n_norm_sat;
    logic [5:0]  n_norm_sh;

    logic [7:0]  ex;
    logic [23:0] sig;
    logic        is_nan;
    logic [14:0] scale;
    logic [23:0] mag24;
    logic [7:0]  shamt;
    logic [7:0]  nsh;

    always_comb begin
        ex     = i_comp[30:23];
        sig    = {1'b1, i_comp[22:0]};
        is_nan = (ex == 8'hFF) && (i_comp[22:0] != 23'd0);
        case (i_ctrl.scale)
            SCALE_127:   scale = 15'd127;
            SCALE_255:   scale = 15'd255;
            SCALE_32767: scale = 15'd32767;
            default:     scale = 15'd127;
        endcase
        n_sign = i_comp[31] && !is_nan;
        shamt  = 8'd150 - ex;
        mag24  = sig >> shamt[4:0];
        if (is_nan || ex < 8'd127) begin
            n_int_mag = 16'd0;
        end else begin
            n_int_mag = mag24[15:0];
        end
        n_int_sat   = !is_nan && (ex > 8'd142);
        n_prod      = {15'd0, sig} * {24'd0, scale};
        n_norm_zero = is_nan || (ex < 8'd110) || (i_comp[31] && !i_ctrl.is_signed);
        n_norm_sat  = ex >= 8'd127;
        nsh         = 8'd150 - ex;
        n_norm_sh   = nsh[5:0];
    end

    always_ff @(posedge i_clk) begin
        r_comp      <= i_comp;
        r_ctrl      <= i_ctrl;
        r_sign      <= n_sign;
        r_int_mag   <= n_int_mag;
        r_int_sat   <= n_int_sat;
        r_prod      <= n_prod;
        r_norm_zero <= n_norm_zero;
        r_norm_sat  <= n_norm_sat;
        r_norm_sh   <= n_norm_sh;
    end

    logic [16:0] lim_pos;
    logic [16:0] lim_neg;
    logic [16:0] mag17;
    logic [16:0] int_m;
    logic [16:0] int_val;
    logic        top_bit;
    logic [3:0]  drop;
    logic [3:0]  drop_m1;
    logic [39:0] prod40;
    logic [39:0] keep;
    logic [39:0] low_mask;
    logic        guard;
    logic        sticky;
    logic        up;
    logic [39:0] rounded;
    logic [39:0] shifted;
    logic [5:0]  sh_m1;
    logic [16:0] norm_mag;
    logic [16:0] norm_val;
    logic [16:0] val;

    always_comb begin
        if (r_ctrl.byte_wide && r_ctrl.is_signed) begin
            lim_pos = 17'd127;
            lim_neg = 17'd128;
        end else if (r_ctrl.byte_wide) begin
            lim_pos = 17'd255;
            lim_neg = 17'd0;
        end else begin
            lim_pos = 17'd32767;
            lim_neg = 17'd32768;
        end
        mag17 = r_int_sat ? 17'h1FFFF : {1'b0, r_int_mag};
        if (r_sign) begin
            int_m   = (mag17 > lim_neg) ? lim_neg : mag17;
            int_val = 17'd0 - int_m;
        end else begin
            int_m   = (mag17 > lim_pos) ? lim_pos : mag17;
            int_val = int_m;
        end

        prod40 = {1'b0, r_prod};
        case (r_ctrl.scale)
            SCALE_127:   begin top_bit = r_prod[30]; drop = top_bit ? 4'd7 : 4'd6; end
            SCALE_255:   begin top_bit = r_prod[31]; drop = top_bit ? 4'd8 : 4'd7; end
            SCALE_32767: begin top_bit = r_prod[38]; drop = top_bit ? 4'd15 : 4'd14; end
            default:     begin top_bit = r_prod[30]; drop = top_bit ? 4'd7 : 4'd6; end
        endcase
        drop_m1  = drop - 4'd1;
        keep     = prod40 >> drop;
        low_mask = (40'd1 << drop_m1) - 40'd1;
        guard    = prod40[{2'd0, drop_m1}];
        sticky   = (prod40 & low_mask) != 40'd0;
        up       = guard && (sticky || keep[0]);
        rounded  = (keep + {39'd0, up}) << drop;
        sh_m1    = r_norm_sh - 6'd1;
        shifted  = rounded >> sh_m1;
        if (r_norm_zero) begin
            norm_mag = 17'd0;
        end else if (r_norm_sat) begin
            norm_mag = (r_ctrl.scale == SCALE_127) ? 17'd127 :
                       (r_ctrl.scale == SCALE_255) ? 17'd255 : 17'd32767;
        end else begin
            norm_mag = {1'b0, shifted[16:1]} + {16'd0, shifted[0]};
        end
        norm_val = r_sign ? (17'd0 - norm_mag) : norm_mag;

        val = (r_ctrl.kind == KIND_NORM) ? norm_val : int_val;
        case (r_ctrl.kind)
            KIND_PASS: o_res = r_comp;
            KIND_INT, KIND_NORM: begin
                o_res = r_ctrl.byte_wide ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
            end
            default:   o_res = 32'd0;
        endcase
    end

endmodule

/* rtl/core/vap_merge.sv */
// Output stage that merges the lane results with the byte count and the error flag.
module vap_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [3:0]         i_mode,
    input  logic [31:0]        i_res_x,
    input  logic [31:0]        i_res_y,
    input  logic [31:0]        i_res_z,
    input  logic [31:0]        i_res_w,
    output logic               o_valid,
    output vap_pkg::t_out_word o_word
);
    import vap_pkg::*;

    logic      r_valid;
    t_out_word r_word;
    t_out_word n_word;

    always_comb begin
        n_word.out_x = i_res_x;
        n_word.out_y = i_res_y;
        n_word.out_z = i_res_z;
        n_word.out_w = i_res_w;
        n_word.unsupported = 1'b0;
        case (i_mode)
            MODE_F1:  n_word.bytes_written = 5'd4;
            MODE_F2:  n_word.bytes_written = 5'd8;
            MODE_F3:  n_word.bytes_written = 5'd12;
            MODE_F4:  n_word.bytes_written = 5'd16;
            MODE_S2, MODE_S2N, MODE_B4, MODE_B4N, MODE_UB4, MODE_UB4N:
                n_word.bytes_written = 5'd4;
            MODE_S4, MODE_S4N: n_word.bytes_written = 5'd8;
            default: begin
                n_word.bytes_written = 5'd0;
                n_word.unsupported   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* rtl/core/vertex_attribute_packer_core.sv */
// Top level of the vertex attribute packer: format decode, four lanes and the output stage.
//
// A word enters when i_start is high and o_busy is low. o_busy is always low, so
// one word can enter on every clock cycle. Each word carries a format code and
// four single-precision components.
// The result word is registered first in the lane registers and then in the output
// register of vap_merge, and is marked by o_valid for exactly one cycle.
// Throughput is one word per cycle: each of the four lanes registers its
// multiplier product, and the rounding logic feeds the output register.
// Float formats pass the component bits through; integer formats clamp and
// truncate; normalized formats clamp, scale, round to single precision and then
// round half away from zero. Unused components read as zero, and an unsupported
// format code gives zero bytes with the unsupported flag set.
// The receiver cannot stall, so every result must be taken in its cycle.
// A synchronous reset clears the valid pipeline; words in flight are dropped.
module vertex_attribute_packer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  vap_pkg::t_in_word  i_word,
    output logic               o_busy,
    output logic               o_valid,
    output vap_pkg::t_out_word o_word
);
    import vap_pkg::*;

    logic       r_valid1;
    logic [3:0] r_mode1;
    logic [31:0] comps [NumLanes];
    logic [31:0] res [NumLanes];
    t_lane_ctrl  ctrl [NumLanes];

    assign o_busy = 1'b0;

    assign comps[0] = i_word.comp_x;
    assign comps[1] = i_word.comp_y;
    assign comps[2] = i_word.comp_z;
    assign comps[3] = i_word.comp_w;

    function automatic t_lane_ctrl lane_ctrl(input logic [3:0] mode, input logic [1:0] idx);
        t_lane_ctrl c;
        c.kind      = KIND_ZERO;
        c.is_signed = 1'b1;
        c.byte_wide = 1'b0;
        c.scale     = SCALE_32767;
        case (mode)
            MODE_F1, MODE_F2, MODE_F3, MODE_F4: begin
                c.kind = ({1'b0, idx} <= {1'b0, mode[1:0]}) ? KIND_PASS : KIND_ZERO;
            end
            MODE_S2:  c.kind = (idx < 2'd2) ? KIND_INT : KIND_ZERO;
            MODE_S2N: c.kind = (idx < 2'd2) ? KIND_NORM : KIND_ZERO;
            MODE_S4:  c.kind = KIND_INT;
            MODE_S4N: c.kind = KIND_NORM;
            MODE_B4: begin
                c.kind = KIND_INT;
                c.byte_wide = 1'b1;
            end
            MODE_B4N: begin
                c.kind = KIND_NORM;
                c.byte_wide = 1'b1;
                c.scale = SCALE_127;
            end
            MODE_UB4: begin
                c.kind = KIND_INT;
                c.byte_wide = 1'b1;
                c.is_signed = 1'b0;
            end
            MODE_UB4N: begin
                c.kind = KIND_NORM;
                c.byte_wide = 1'b1;
                c.is_signed = 1'b0;
                c.scale = SCALE_255;
            end
            default: c.kind = KIND_ZERO;
        endcase
        return c;
    endfunction

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        assign ctrl[g] = lane_ctrl(i_word.mode, 2'(g));
        vap_lane u_lane (
            .i_clk  (i_clk),
            .i_comp (comps[g]),
            .i_ctrl (ctrl[g]),
            .o_res  (res[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= i_start && !o_busy;
        end
        r_mode1 <= i_word.mode;
    end

    vap_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid1),
        .i_mode  (r_mode1),
        .i_res_x (res[0]),
        .i_res_y (res[1]),
        .i_res_z (res[2]),
        .i_res_w (res[3]),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    a_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid1 |=> o_valid)
        else $error("A word in the first stage did not reach the output.");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid1 |=> !o_valid)
        else $error("A result appeared without a word in flight.");
    a_unsup_empty: assert property (@(posedge i_clk)
        (o_valid && o_word.unsupported) |-> (o_word.bytes_written == 5'd0 &&
        o_word.out_x == 32'd0 && o_word.out_w == 32'd0))
        else $error("An unsupported format produced data.");
    a_bytes_range: assert property (@(posedge i_clk)
        o_valid |-> (o_word.bytes_written <= 5'd16))
        else $error("The byte count is out of range.");

endmodule
